[src/blocked_sorted_key_table_defines.svh]
// ----------------------------------------------------------------------------
// blocked sorted key table assertion macros
// concurrent assertion helpers, empty bodies when building for synthesis
// ----------------------------------------------------------------------------
`ifndef BLOCKED_SORTED_KEY_TABLE_DEFINES_SVH
`define BLOCKED_SORTED_KEY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define SBKT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sbkt assertion failed");
// checked on every clock edge, reset included
`define SBKT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("sbkt assertion failed");
`else
`define SBKT_ASSERT(label, prop)
`define SBKT_ASSERT_ALWAYS(label, prop)
`endif

`endif

[src/sbkt_pkg.sv]
// ----------------------------------------------------------------------------
// sbkt_pkg
// field widths, action and status codes and shared types of the key table
// ----------------------------------------------------------------------------
package sbkt_pkg;

   localparam int KEY_W  = 17;
   localparam int VAL_W  = 14;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;
   localparam int CFG_W  = 7;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic [ACT_W-1:0] ACT_FIND   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CHANGE = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [VAL_W-1:0]  value_type;
   typedef logic [ACT_W-1:0]  action_type;
   typedef logic [STAT_W-1:0] status_type;

   // outcome of one block update
   typedef struct packed {
      status_type status;
      value_type  found;
      logic       row_we;
      logic       index_we;
      key_type    first_key;
   } exec_result_type;

endpackage

[src/sbkt_ram.sv]
// ----------------------------------------------------------------------------
// sbkt_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sbkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/sbkt_block_alu.sv]
// ----------------------------------------------------------------------------
// sbkt_block_alu
// scans one block row and builds the updated row and the status
// ----------------------------------------------------------------------------
module sbkt_block_alu #(
   parameter int BLOCK_SLOTS = 8,
   parameter int CW          = 4
) (
   input  sbkt_pkg::action_type                   action,
   input  sbkt_pkg::key_type                      key,
   input  sbkt_pkg::value_type                    value,
   input  logic [CW-1:0]                          cnt,
   input  sbkt_pkg::key_type   [BLOCK_SLOTS-1:0]  keys,
   input  sbkt_pkg::value_type [BLOCK_SLOTS-1:0]  values,
   output logic [CW-1:0]                          new_cnt,
   output sbkt_pkg::key_type   [BLOCK_SLOTS-1:0]  new_keys,
   output sbkt_pkg::value_type [BLOCK_SLOTS-1:0]  new_values,
   output sbkt_pkg::exec_result_type              result
);
   import sbkt_pkg::*;

   localparam int SAW = $clog2(BLOCK_SLOTS);

   logic          hit_found;
   logic [CW-1:0] hit;
   logic [CW-1:0] ins;
   logic          full;

   always_comb begin
      hit_found = 1'b0;
      hit       = '0;
      ins       = '0;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
         if (CW'(i) < cnt) begin
            if (!hit_found && keys[i] == key) begin
               hit_found = 1'b1;
               hit       = CW'(i);
            end
            if (keys[i] < key) begin
               ins = CW'(i + 1);
            end
         end
      end
      full = (cnt >= CW'(BLOCK_SLOTS));
   end

   always_comb begin
      new_cnt          = cnt;
      new_keys         = keys;
      new_values       = values;
      result.status    = STAT_NOT_FOUND;
      result.found     = '0;
      result.row_we    = 1'b0;
      result.index_we  = 1'b0;
      result.first_key = key;
      case (action)
         ACT_FIND: begin
            if (hit_found) begin
               result.status = STAT_OK;
               result.found  = values[hit[SAW-1:0]];
            end
         end
         ACT_ADD: begin
            if (full) begin
               result.status = STAT_FULL;
            end else if (hit_found) begin
               result.status = STAT_DUPLICATE;
            end else begin
               // open a gap at the insert point, shift the tail up
               for (int i = 0; i < BLOCK_SLOTS; i++) begin
                  if (CW'(i) == ins) begin
                     new_keys[i]   = key;
                     new_values[i] = value;
                  end else if (CW'(i) > ins && CW'(i) <= cnt) begin
                     new_keys[i]   = keys[(i > 0) ? i - 1 : 0];
                     new_values[i] = values[(i > 0) ? i - 1 : 0];
                  end
               end
               new_cnt          = cnt + CW'(1);
               result.status    = STAT_OK;
               result.row_we    = 1'b1;
               result.index_we  = (ins == '0);
               result.first_key = key;
            end
         end
         ACT_REMOVE: begin
            if (hit_found) begin
               // close the gap, clear the freed top slot
               for (int i = 0; i < BLOCK_SLOTS; i++) begin
                  if (CW'(i) + CW'(1) == cnt) begin
                     new_keys[i]   = '0;
                     new_values[i] = '0;
                  end else if (CW'(i) >= hit && CW'(i) + CW'(1) < cnt) begin
                     new_keys[i]   = keys[(i < BLOCK_SLOTS - 1) ? i + 1 : i];
                     new_values[i] = values[(i < BLOCK_SLOTS - 1) ? i + 1 : i];
                  end
               end
               new_cnt          = cnt - CW'(1);
               result.status    = STAT_OK;
               result.row_we    = 1'b1;
               result.index_we  = (hit == '0);
               result.first_key = new_keys[0];
            end
         end
         ACT_CHANGE: begin
            if (hit_found) begin
               new_values[hit[SAW-1:0]] = value;
               result.status            = STAT_OK;
               result.row_we            = 1'b1;
            end
         end
         default: begin
            result.status = STAT_NOT_FOUND;
         end
      endcase
   end

endmodule

[src/blocked_sorted_key_table.sv]
// ----------------------------------------------------------------------------
// blocked_sorted_key_table
// indexed sequential key/value table: binary search over block first keys,
// then a single row read, update and write back of the chosen block
// ----------------------------------------------------------------------------
//
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  req_tdata: action, key, value
// rsp       out   rsp_tvalid/rsp_tready  rsp_tdata: status, found_value
// csr       in    csr_valid/csr_ready    csr_data: blocks_in_use
//
// a transaction is accepted, then each index probe reads and compares a
// first key, with floor(log2(n))+1 probes for n blocks searched, then the
// chosen row is read and updated
// the index memory's single read port sets the probe cost
// after reset a clearing pass zeroes both memories, during which no request
// transaction is taken
// a waiting response stalls only the write back; a new request is taken
// while the previous response is still held
//
`include "blocked_sorted_key_table_defines.svh"

module blocked_sorted_key_table #(
   parameter int BLOCK_SLOTS = 8,
   parameter int NUM_BLOCKS  = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [1:0] action, [18:2] key, [32:19] value, [39:33] unused
   input  logic [39:0]                req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [1:0] status, [15:2] found_value
   output logic [15:0]                rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sbkt_pkg::CFG_W-1:0] csr_data
);
   import sbkt_pkg::*;

   localparam int IAW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int NCL = $clog2(NUM_BLOCKS + 1);
   localparam int NW  = (NCL > CFG_W) ? NCL : CFG_W;
   localparam int PW  = NW + 2;
   localparam int SHW = $clog2(NW + 3);
   localparam int CW  = $clog2(BLOCK_SLOTS + 1);
   localparam int RW  = CW + BLOCK_SLOTS * (KEY_W + VAL_W);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PRD   = 3'd2;
   localparam logic [2:0] ST_PCMP  = 3'd3;
   localparam logic [2:0] ST_BRD   = 3'd4;
   localparam logic [2:0] ST_EXEC  = 3'd5;

   // control and request registers
   logic [2:0]           state_ff, state_in;
   logic [CFG_W-1:0]     cfg_ff;
   logic [IAW-1:0]       clr_ff, clr_in;
   action_type           act_ff, act_in;
   key_type              key_ff, key_in;
   value_type            val_ff, val_in;
   logic signed [PW-1:0] pos_ff, pos_in;
   logic [SHW-1:0]       sh_ff, sh_in;
   logic [IAW-1:0]       blk_ff, blk_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   value_type            rsp_found_ff, rsp_found_in;

   // search arithmetic
   logic [NW-1:0]        n_blocks;
   logic [NW-1:0]        cfg_ext;
   logic signed [PW-1:0] n_max;
   logic signed [PW-1:0] pos_clamped;
   logic [NW+1:0]        delta_sum;
   logic [NW+1:0]        delta_next;
   logic signed [PW-1:0] pos_step;
   logic signed [PW-1:0] pos_final;
   logic                 key_below;

   // memory ports
   logic                 idx_we;
   logic [IAW-1:0]       idx_waddr;
   key_type              idx_wdata;
   key_type              idx_rdata;
   logic                 row_we;
   logic [IAW-1:0]       row_waddr;
   logic [RW-1:0]        row_wdata;
   logic [RW-1:0]        row_rdata;

   // block row fields
   logic [CW-1:0]                   row_cnt, new_cnt;
   key_type   [BLOCK_SLOTS-1:0]     row_keys, new_keys;
   value_type [BLOCK_SLOTS-1:0]     row_values, new_values;
   exec_result_type                 exec_res;
   logic                            exec_go;
   logic                            req_fire;

   function automatic logic signed [PW-1:0] clamp_pos(input logic signed [PW-1:0] p,
                                                      input logic signed [PW-1:0] hi);
      logic signed [PW-1:0] r;
      r = p;
      if (p < 0) begin
         r = '0;
      end else if (p > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // blocks_in_use of zero acts as one, above the table size acts as the size
   always_comb begin
      cfg_ext = NW'(cfg_ff);
      if (cfg_ext == '0) begin
         n_blocks = NW'(1);
      end else if (cfg_ext > NW'(NUM_BLOCKS)) begin
         n_blocks = NW'(NUM_BLOCKS);
      end else begin
         n_blocks = cfg_ext;
      end
   end

   assign n_max       = $signed({2'b00, n_blocks}) - PW'(1);
   assign pos_clamped = clamp_pos(pos_ff, n_max);

   // next delta: (n + 2^sh) >> (sh + 1)
   assign delta_sum  = {2'b00, n_blocks} + ((NW + 2)'(1) << sh_ff);
   assign delta_next = delta_sum >> (sh_ff + SHW'(1));
   assign key_below  = (key_ff < idx_rdata);
   assign pos_step   = key_below ? (pos_ff - $signed(delta_next))
                                 : (pos_ff + $signed(delta_next));
   assign pos_final  = clamp_pos(pos_step - (key_below ? PW'(1) : PW'(0)), n_max);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      sh_in         = sh_ff;
      blk_in        = blk_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IAW'(1);
            if (clr_ff == IAW'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               act_in   = req_tdata[1:0];
               key_in   = req_tdata[18:2];
               val_in   = req_tdata[32:19];
               // first probe at ((n + 1) >> 1) - 1
               pos_in   = $signed(PW'(({1'b0, n_blocks} + (NW + 1)'(1)) >> 1)) - PW'(1);
               sh_in    = SHW'(1);
               state_in = ST_PRD;
            end
         end
         ST_PRD: begin
            pos_in   = pos_clamped;
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            if (delta_next == '0) begin
               blk_in   = pos_final[IAW-1:0];
               state_in = ST_BRD;
            end else begin
               pos_in   = pos_step;
               sh_in    = sh_ff + SHW'(1);
               state_in = ST_PRD;
            end
         end
         ST_BRD: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = exec_res.status;
               rsp_found_in  = exec_res.found;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      sh_ff         <= sh_in;
      blk_ff        <= blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   // memory write ports: clearing pass, then write back of the executed block;
   // reads of a block always start after its write back, so no forwarding
   always_comb begin
      idx_we    = 1'b0;
      idx_waddr = blk_ff;
      idx_wdata = exec_res.first_key;
      row_we    = 1'b0;
      row_waddr = blk_ff;
      row_wdata = {new_cnt, new_keys, new_values};
      if (state_ff == ST_CLEAR) begin
         idx_we    = 1'b1;
         idx_waddr = clr_ff;
         idx_wdata = '0;
         row_we    = 1'b1;
         row_waddr = clr_ff;
         row_wdata = '0;
      end else if (exec_go) begin
         idx_we = exec_res.index_we;
         row_we = exec_res.row_we;
      end
   end

   // index of block first keys
   sbkt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (NUM_BLOCKS),
      .AW    (IAW)
   ) u_index_ram (
      .clock (clock),
      .we    (idx_we),
      .waddr (idx_waddr),
      .wdata (idx_wdata),
      .raddr (pos_clamped[IAW-1:0]),
      .rdata (idx_rdata)
   );

   // one row per block: slot count, keys, values
   sbkt_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_BLOCKS),
      .AW    (IAW)
   ) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .raddr (blk_ff),
      .rdata (row_rdata)
   );

   assign {row_cnt, row_keys, row_values} = row_rdata;

   // scan and update of the chosen block
   sbkt_block_alu #(
      .BLOCK_SLOTS (BLOCK_SLOTS),
      .CW          (CW)
   ) u_block_alu (
      .action     (act_ff),
      .key        (key_ff),
      .value      (val_ff),
      .cnt        (row_cnt),
      .keys       (row_keys),
      .values     (row_values),
      .new_cnt    (new_cnt),
      .new_keys   (new_keys),
      .new_values (new_values),
      .result     (exec_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_found_ff, rsp_status_ff};

   // no request taken during the clearing pass
   `SBKT_ASSERT(a_no_req_in_clear, (state_ff == ST_CLEAR) |-> !req_tready)
   // a response appears only out of the execute step
   `SBKT_ASSERT(a_rsp_from_exec, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
   // the chosen block lies inside the searched range
   `SBKT_ASSERT(a_blk_in_range, (state_ff == ST_BRD) |-> (NW'(blk_ff) < n_blocks))

endmodule
